// ----- rtl/core/nnds_pkg.sv -----
package nnds_pkg;

  localparam int unsigned MAX_DIMENSION = 4096;
  localparam int unsigned DIM_W = 13;
  localparam int unsigned POS_W = 25;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [1:0] slot_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOURCE_WIDTH     = 3'd0,
    REG_SOURCE_HEIGHT    = 3'd1,
    REG_LIMIT_WIDTH      = 3'd2,
    REG_LIMIT_HEIGHT     = 3'd3,
    REG_FOUR_BYTE_PIXELS = 3'd4
  } cfg_reg_t;

  localparam slot_t SLOT_FIRST = 2'd0;
  localparam slot_t SLOT_BLUE = 2'd2;
  localparam slot_t SLOT_ALPHA = 2'd3;

  function automatic dim_t clamp_dim(input dim_t v);
    dim_t r;
    r = (v > dim_t'(MAX_DIMENSION)) ? dim_t'(MAX_DIMENSION) : v;
    return r;
  endfunction

endpackage

// ----- rtl/core/nnds_source_if.sv -----
interface nnds_source_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

// ----- rtl/core/nnds_result_if.sv -----
interface nnds_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       frame_last;

  modport source (output valid, output pixel_byte, output frame_last, input ready);
  modport sink (input valid, input pixel_byte, input frame_last, output ready);
endinterface

// ----- rtl/core/nnds_cfg_if.sv -----
interface nnds_cfg_if import nnds_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [DIM_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/nearest_neighbor_downscaler.sv -----
// Nearest-neighbor downscaler for a raster byte stream.
// The source channel takes one source byte per request, R G B or R G B A per
// pixel as set by the four-byte-pixels register. The result channel gives the
// RGB24 bytes of the kept pixels in raster order, with frame_last set on the
// blue byte of the final output pixel. The output size is the source size
// clamped to the limit registers; a zero limit consumes frames silently.
// The cfg channel writes registers 0 to 4 (source width, source height, limit
// width, limit height, four-byte pixels) and is always ready. Writes take
// effect on the next source byte and are meant for idle periods.
// Each accepted source byte that yields a result is registered, and one source
// byte is accepted every cycle while the output is empty or being taken. The
// rate is set by the single output register: while it holds a result the
// receiver has not taken, the source channel is held off, so a stall on the
// result side stalls the source side in the same cycle, also for bytes that produce no result.
// Reset restores the register defaults (640 x 480 to 320 x 240, RGB), clears
// the frame position and empties the output register.
module nearest_neighbor_downscaler import nnds_pkg::*; (
  input logic          clk,
  input logic          rst,
  nnds_source_if.sink  source,
  nnds_result_if.source result,
  nnds_cfg_if.sink     cfg
);

  dim_t source_width;
  dim_t source_height;
  dim_t limit_width;
  dim_t limit_height;
  logic four_byte_pixels;

  slot_t byte_slot;
  dim_t  column_index;
  dim_t  row_index;
  pos_t  column_scaled_position;
  pos_t  column_next_target;
  dim_t  columns_emitted;
  pos_t  row_scaled_position;
  pos_t  row_next_target;
  dim_t  rows_emitted;
  logic  pixel_selected;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  dim_t sw, sh, lw, lh, dw, dh;
  slot_t last_slot;
  logic col_sel, row_sel, sel, emit, last, pixel_end, accept;
  logic col_wrap, row_wrap;
  dim_t column_index_next, row_index_next;

  assign sw = clamp_dim(source_width);
  assign sh = clamp_dim(source_height);
  assign lw = clamp_dim(limit_width);
  assign lh = clamp_dim(limit_height);
  assign dw = (lw < sw) ? lw : sw;
  assign dh = (lh < sh) ? lh : sh;
  assign last_slot = four_byte_pixels ? SLOT_ALPHA : SLOT_BLUE;

  assign col_sel = (columns_emitted < dw) &&
                   ({1'b0, column_next_target} <
                    ({1'b0, column_scaled_position} + (POS_W+1)'(dw)));
  assign row_sel = (rows_emitted < dh) &&
                   ({1'b0, row_next_target} <
                    ({1'b0, row_scaled_position} + (POS_W+1)'(dh)));
  assign sel = (byte_slot == SLOT_FIRST) ? (col_sel && row_sel) : pixel_selected;
  assign emit = sel && (byte_slot != SLOT_ALPHA);
  assign last = (byte_slot == SLOT_BLUE) &&
                (({1'b0, columns_emitted} + (DIM_W+1)'(1)) == {1'b0, dw}) &&
                (({1'b0, rows_emitted} + (DIM_W+1)'(1)) == {1'b0, dh});
  assign pixel_end = byte_slot >= last_slot;

  assign column_index_next = column_index + dim_t'(1);
  assign row_index_next = row_index + dim_t'(1);
  assign col_wrap = column_index_next >= sw;
  assign row_wrap = row_index_next >= sh;

  assign source.ready = !out_valid || result.ready;
  assign accept = source.valid && source.ready;
  assign cfg.ready = 1'b1;

  assign result.valid = out_valid;
  assign result.pixel_byte = out_byte;
  assign result.frame_last = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width <= dim_t'(640);
      source_height <= dim_t'(480);
      limit_width <= dim_t'(320);
      limit_height <= dim_t'(240);
      four_byte_pixels <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SOURCE_WIDTH: source_width <= cfg.data;
        REG_SOURCE_HEIGHT: source_height <= cfg.data;
        REG_LIMIT_WIDTH: limit_width <= cfg.data;
        REG_LIMIT_HEIGHT: limit_height <= cfg.data;
        REG_FOUR_BYTE_PIXELS: four_byte_pixels <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_slot <= SLOT_FIRST;
      column_index <= '0;
      row_index <= '0;
      column_scaled_position <= '0;
      column_next_target <= '0;
      columns_emitted <= '0;
      row_scaled_position <= '0;
      row_next_target <= '0;
      rows_emitted <= '0;
      pixel_selected <= 1'b0;
    end else if (accept) begin
      if (byte_slot == SLOT_FIRST) begin
        pixel_selected <= col_sel && row_sel;
      end
      if (pixel_end) begin
        byte_slot <= SLOT_FIRST;
        if (!col_wrap) begin
          column_index <= column_index_next;
          column_scaled_position <= column_scaled_position + pos_t'(dw);
          if (col_sel) begin
            columns_emitted <= columns_emitted + dim_t'(1);
            column_next_target <= column_next_target + pos_t'(sw);
          end
        end else begin
          column_index <= '0;
          column_scaled_position <= '0;
          column_next_target <= '0;
          columns_emitted <= '0;
          if (!row_wrap) begin
            row_index <= row_index_next;
            row_scaled_position <= row_scaled_position + pos_t'(dh);
            if (row_sel) begin
              rows_emitted <= rows_emitted + dim_t'(1);
              row_next_target <= row_next_target + pos_t'(sh);
            end
          end else begin
            row_index <= '0;
            row_scaled_position <= '0;
            row_next_target <= '0;
            rows_emitted <= '0;
            pixel_selected <= 1'b0;
          end
        end
      end else begin
        byte_slot <= byte_slot + slot_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_byte <= source.source_byte;
      out_last <= last;
    end
  end

endmodule
